/* design/ssa_pkg.sv */
// ----------------------------------------------------------------------------
// ssa_pkg
// shared constants, size class tables and helpers for the slab allocator
// ----------------------------------------------------------------------------
package ssa_pkg;

  localparam int UNIT_BYTES      = 16;
  localparam int MAX_SMALL_BYTES = 256;
  localparam int PAGE_BYTES      = 4096;
  localparam int NUM_PAGES       = 256;
  localparam int NUM_CLASSES     = MAX_SMALL_BYTES / UNIT_BYTES;
  localparam int HEAP_SLOTS      = NUM_PAGES * (PAGE_BYTES / UNIT_BYTES);

  localparam int ADDR_W  = 20;
  localparam int UNIT_W  = 4;
  localparam int PAGE_SH = 12;
  localparam int SLOT_W  = ADDR_W - UNIT_W;
  localparam int PAGE_W  = 8;
  localparam int CLS_W   = 4;
  localparam int USE_W   = 8;
  localparam int CNT_W   = 17;
  localparam int TOP_W   = 9;
  localparam int STEP_W  = 17;

  localparam logic [ADDR_W-1:0] LIST_END = '0;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_PAGE = 2'd1;
  localparam logic [1:0] ST_OUTSIDE = 2'd2;

  // slots per page for each class, header slot included
  localparam logic [8:0] SLOTS_TBL [NUM_CLASSES] = '{
    9'd256, 9'd128, 9'd85, 9'd64, 9'd51, 9'd42, 9'd36, 9'd32,
    9'd28,  9'd25,  9'd23, 9'd21, 9'd19, 9'd18, 9'd17, 9'd16
  };

  // free slot margin that triggers decommit of the pending page
  localparam logic [9:0] MARGIN_TBL [NUM_CLASSES] = '{
    10'd384, 10'd192, 10'd127, 10'd96, 10'd76, 10'd63, 10'd54, 10'd48,
    10'd42,  10'd37,  10'd34,  10'd31, 10'd28, 10'd27, 10'd25, 10'd24
  };

  function automatic logic [8:0] elem_bytes(input logic [CLS_W-1:0] c);
    logic [4:0] k;
    k = {1'b0, c} + 5'd1;
    return {k, 4'b0000};
  endfunction

  function automatic logic [TOP_W-1:0] eff_pages(input logic [8:0] r);
    return (r > 9'(NUM_PAGES)) ? 9'(NUM_PAGES) : r;
  endfunction

endpackage

/* design/ssa_ram.sv */
// ----------------------------------------------------------------------------
// ssa_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module ssa_ram #(
  parameter int AW = 8,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/size_class_slab_allocator.sv */
// ----------------------------------------------------------------------------
// size_class_slab_allocator
// segregated free list allocator over fixed size pages, sequenced over rams
// ----------------------------------------------------------------------------
// rejected items answer from idle; allocate runs al_rd, al_wb; free fr_wb,
// fr_inc; a fresh page adds cm_pop, then cm_thread slot by slot; decommit
// adds dc_rd, dc_cls, er_rd and er_wb per list element walked on the link
// ram port, dc_fin. one item at a time: busy falls with the done strobe, next
// item taken then. results are a one cycle strobe, the receiver cannot stall
// rst or a config write reinitialises lists, counts and the page stack at once
module size_class_slab_allocator
  import ssa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic                 req_type,
  input  logic [8:0]           request_size,
  input  logic [ADDR_W-1:0]    block_offset,
  output logic                 done,
  output logic [1:0]           status,
  output logic [ADDR_W-1:0]    block_address,
  output logic                 released_page_valid,
  output logic [PAGE_W-1:0]    released_page,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [8:0]           cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_CM_POP, S_CM_THREAD, S_AL_RD, S_AL_WB, S_FR_WB, S_FR_INC,
    S_DC_RD, S_DC_CLS, S_ER_RD, S_ER_WB, S_DC_FIN
  } state_t;

  state_t state;

  logic [8:0]        reserve;
  logic [ADDR_W-1:0] head    [NUM_CLASSES];
  logic              pend_v  [NUM_CLASSES];
  logic [PAGE_W-1:0] pend    [NUM_CLASSES];
  logic [CNT_W-1:0]  fc      [NUM_CLASSES];
  logic [TOP_W-1:0]  top;
  logic [NUM_PAGES-1:0] sv;

  logic [CLS_W-1:0]  cls_q;
  logic [ADDR_W-1:0] off_q;
  logic [PAGE_W-1:0] pg_q;
  logic [ADDR_W-1:0] thr_off;
  logic [8:0]        thr_i;
  logic [ADDR_W-1:0] base_q;
  logic [PAGE_W-1:0] stk_addr;
  logic [PAGE_W-1:0] dc_page;
  logic [CLS_W-1:0]  dc_cls;
  logic [ADDR_W-1:0] cur;
  logic [ADDR_W-1:0] prev;
  logic              prev_none;
  logic [STEP_W-1:0] steps;
  logic              ret_inc;

  // ram ports
  logic              lk_we;
  logic [SLOT_W-1:0] lk_waddr, lk_raddr;
  logic [ADDR_W-1:0] lk_wdata, lk_rdata;
  logic              us_we;
  logic [PAGE_W-1:0] us_waddr, us_raddr;
  logic [USE_W-1:0]  us_wdata, us_rdata;
  logic              cl_we;
  logic [PAGE_W-1:0] cl_waddr, cl_raddr;
  logic [CLS_W-1:0]  cl_wdata, cl_rdata;
  logic              sk_we;
  logic [PAGE_W-1:0] sk_waddr;
  logic [PAGE_W-1:0] sk_wdata, sk_rdata;

  logic [CLS_W-1:0]  req_cls;
  logic [8:0]        size_m1;
  logic [ADDR_W-1:0] req_off;
  logic [PAGE_W-1:0] pop_page;
  logic [8:0]        elem;
  logic [8:0]        nslots;
  logic              thr_last;
  logic              cur_in_page;
  logic [TOP_W-1:0]  top_next;
  logic [8:0]        dc_slots;
  logic [CNT_W-1:0]  fc_inc;

  assign size_m1  = request_size - 9'd1;
  assign req_cls  = (request_size == 9'd0) ? '0 : size_m1[7:4];
  assign req_off  = {block_offset[ADDR_W-1:UNIT_W], {UNIT_W{1'b0}}};
  assign pop_page = sv[stk_addr] ? sk_rdata : stk_addr;
  assign elem     = elem_bytes(cls_q);
  assign nslots   = SLOTS_TBL[cls_q];
  assign thr_last = (thr_i + 9'd1) == nslots;
  assign cur_in_page = cur[ADDR_W-1:PAGE_SH] == dc_page;
  assign top_next = top + 9'd1;
  assign dc_slots = SLOTS_TBL[dc_cls];
  assign fc_inc   = fc[cls_q] + 17'd1;

  assign busy      = (state != S_IDLE);
  // an item offered in the same cycle goes first
  assign cfg_ready = (state == S_IDLE) && !start;

  always_comb begin
    lk_we    = 1'b0;
    lk_waddr = thr_off[ADDR_W-1:UNIT_W];
    lk_wdata = thr_last ? LIST_END : (thr_off + {11'd0, elem});
    lk_raddr = cur[ADDR_W-1:UNIT_W];
    us_we    = 1'b0;
    us_waddr = pg_q;
    us_wdata = '0;
    us_raddr = block_offset[ADDR_W-1:PAGE_SH];
    cl_we    = 1'b0;
    cl_waddr = pop_page;
    cl_wdata = cls_q;
    cl_raddr = block_offset[ADDR_W-1:PAGE_SH];
    sk_we    = 1'b0;
    sk_waddr = top_next[PAGE_W-1:0];
    sk_wdata = dc_page;
    case (state)
      S_CM_POP: begin
        us_we    = 1'b1;
        us_waddr = pop_page;
        us_wdata = '0;
        cl_we    = 1'b1;
      end
      S_CM_THREAD: begin
        lk_we = 1'b1;
      end
      S_AL_RD: begin
        lk_raddr = head[cls_q][ADDR_W-1:UNIT_W];
        us_raddr = head[cls_q][ADDR_W-1:PAGE_SH];
      end
      S_AL_WB: begin
        us_we    = 1'b1;
        us_wdata = us_rdata + 8'd1;
      end
      S_FR_WB: begin
        us_we    = 1'b1;
        us_wdata = us_rdata - 8'd1;
        lk_we    = 1'b1;
        lk_waddr = off_q[ADDR_W-1:UNIT_W];
        lk_wdata = head[cl_rdata];
      end
      S_DC_RD: begin
        cl_raddr = dc_page;
      end
      S_ER_WB: begin
        lk_we    = cur_in_page && !prev_none;
        lk_waddr = prev[ADDR_W-1:UNIT_W];
        lk_wdata = lk_rdata;
      end
      S_DC_FIN: begin
        sk_we = !top_next[TOP_W-1];
      end
      default: begin
      end
    endcase
  end

  ssa_ram #(.AW(SLOT_W), .DW(ADDR_W)) u_link (
    .clk(clk), .we(lk_we), .waddr(lk_waddr), .wdata(lk_wdata),
    .raddr(lk_raddr), .rdata(lk_rdata)
  );

  ssa_ram #(.AW(PAGE_W), .DW(USE_W)) u_use (
    .clk(clk), .we(us_we), .waddr(us_waddr), .wdata(us_wdata),
    .raddr(us_raddr), .rdata(us_rdata)
  );

  ssa_ram #(.AW(PAGE_W), .DW(CLS_W)) u_class (
    .clk(clk), .we(cl_we), .waddr(cl_waddr), .wdata(cl_wdata),
    .raddr(cl_raddr), .rdata(cl_rdata)
  );

  ssa_ram #(.AW(PAGE_W), .DW(PAGE_W)) u_stack (
    .clk(clk), .we(sk_we), .waddr(sk_waddr), .wdata(sk_wdata),
    .raddr(top[PAGE_W-1:0]), .rdata(sk_rdata)
  );

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst || (cfg_valid && cfg_ready)) begin
      state <= S_IDLE;
      if (rst) begin
        reserve <= 9'(NUM_PAGES);
        top     <= 9'(NUM_PAGES) - 9'd1;
      end else begin
        reserve <= cfg_data;
        top     <= eff_pages(cfg_data) - 9'd1;
      end
      sv <= '0;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        head[i]   <= LIST_END;
        pend_v[i] <= 1'b0;
        fc[i]     <= '0;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            released_page_valid <= 1'b0;
            released_page       <= '0;
            block_address       <= '0;
            status              <= ST_OK;
            ret_inc             <= 1'b0;
            if (!req_type) begin
              cls_q <= req_cls;
              if (request_size > 9'(MAX_SMALL_BYTES)) begin
                status <= ST_NO_PAGE;
                done   <= 1'b1;
              end else if (head[req_cls] != LIST_END) begin
                state <= S_AL_RD;
              end else if (top[TOP_W-1]) begin
                status <= ST_NO_PAGE;
                done   <= 1'b1;
              end else begin
                stk_addr <= top[PAGE_W-1:0];
                state    <= S_CM_POP;
              end
            end else begin
              off_q <= req_off;
              pg_q  <= req_off[ADDR_W-1:PAGE_SH];
              if ({1'b0, req_off[ADDR_W-1:PAGE_SH]} >= eff_pages(reserve)) begin
                status <= ST_OUTSIDE;
                done   <= 1'b1;
              end else begin
                state <= S_FR_WB;
              end
            end
          end
        end
        S_CM_POP: begin
          top     <= top - 9'd1;
          base_q  <= {pop_page, {PAGE_SH{1'b0}}};
          thr_off <= {pop_page, {PAGE_SH{1'b0}}} + {11'd0, elem};
          thr_i   <= 9'd1;
          state   <= S_CM_THREAD;
        end
        S_CM_THREAD: begin
          thr_off <= thr_off + {11'd0, elem};
          thr_i   <= thr_i + 9'd1;
          if (thr_last) begin
            head[cls_q] <= base_q + {11'd0, elem};
            fc[cls_q]   <= fc[cls_q] + {8'd0, nslots} - 17'd1;
            state       <= S_AL_RD;
          end
        end
        S_AL_RD: begin
          off_q <= head[cls_q];
          pg_q  <= head[cls_q][ADDR_W-1:PAGE_SH];
          state <= S_AL_WB;
        end
        S_AL_WB: begin
          head[cls_q] <= lk_rdata;
          fc[cls_q]   <= fc[cls_q] - 17'd1;
          if (pend_v[cls_q] && pend[cls_q] == pg_q) begin
            pend_v[cls_q] <= 1'b0;
          end
          block_address <= off_q;
          done          <= 1'b1;
          state         <= S_IDLE;
        end
        S_FR_WB: begin
          cls_q          <= cl_rdata;
          head[cl_rdata] <= off_q;
          state          <= S_FR_INC;
          if (us_rdata == 8'd1 && !(pend_v[cl_rdata] && pend[cl_rdata] == pg_q)) begin
            pend_v[cl_rdata] <= 1'b1;
            pend[cl_rdata]   <= pg_q;
            if (pend_v[cl_rdata]) begin
              // old pending page gives way to this one
              dc_page <= pend[cl_rdata];
              ret_inc <= 1'b1;
              state   <= S_DC_RD;
            end
          end
        end
        S_FR_INC: begin
          fc[cls_q] <= fc_inc;
          ret_inc   <= 1'b0;
          if ({7'd0, MARGIN_TBL[cls_q]} <= fc_inc && pend_v[cls_q]) begin
            pend_v[cls_q] <= 1'b0;
            dc_page       <= pend[cls_q];
            state         <= S_DC_RD;
          end else begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_DC_RD: begin
          state <= S_DC_CLS;
        end
        S_DC_CLS: begin
          dc_cls    <= cl_rdata;
          cur       <= head[cl_rdata];
          prev_none <= 1'b1;
          steps     <= '0;
          state     <= (head[cl_rdata] == LIST_END) ? S_DC_FIN : S_ER_RD;
        end
        S_ER_RD: begin
          state <= S_ER_WB;
        end
        S_ER_WB: begin
          if (cur_in_page) begin
            if (prev_none) begin
              head[dc_cls] <= lk_rdata;
            end
          end else begin
            prev      <= cur;
            prev_none <= 1'b0;
          end
          cur   <= lk_rdata;
          steps <= steps + 17'd1;
          if (lk_rdata != LIST_END && (steps + 17'd1) < 17'(HEAP_SLOTS)) begin
            state <= S_ER_RD;
          end else begin
            state <= S_DC_FIN;
          end
        end
        S_DC_FIN: begin
          if (!top_next[TOP_W-1]) begin
            top               <= top_next;
            sv[top_next[PAGE_W-1:0]] <= 1'b1;
          end
          fc[dc_cls]          <= fc[dc_cls] - {8'd0, dc_slots} + 17'd1;
          released_page_valid <= 1'b1;
          released_page       <= dc_page;
          if (ret_inc) begin
            state <= S_FR_INC;
          end else begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* design/ssa_checker.sv */
// ----------------------------------------------------------------------------
// ssa_checker
// port level checks on the result strobe of the slab allocator
// ----------------------------------------------------------------------------
module ssa_checker
  import ssa_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input logic [1:0]        status,
  input logic [ADDR_W-1:0] block_address,
  input logic              released_page_valid,
  input logic [PAGE_W-1:0] released_page
);

  // a failed request hands out no block
  a_fail_no_addr: assert property (@(posedge clk) disable iff (rst)
    done && status != ST_OK |-> block_address == '0)
    else $error("failed request with nonzero address");

  // rejected items never release a page
  a_fail_no_rel: assert property (@(posedge clk) disable iff (rst)
    done && status != ST_OK |-> !released_page_valid)
    else $error("failed request released a page");

  // no page index without the valid flag
  a_rel_zero: assert property (@(posedge clk) disable iff (rst)
    done && !released_page_valid |-> released_page == '0)
    else $error("released page set while not valid");

  // a result only follows an accepted item or busy time
  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) || $past(start))
    else $error("result without an item");

endmodule

bind size_class_slab_allocator ssa_checker u_ssa_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .status(status), .block_address(block_address),
  .released_page_valid(released_page_valid), .released_page(released_page)
);
